### rtl/awcr_pkg.sv
`default_nettype none

package awcr_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } awcr_state_t;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic start;   // latch request, reset scan trackers
        logic step;    // advance the entry scan
        logic commit;  // apply replacement or clear, load result registers
    } awcr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_clear;   // latched request is a clear
        logic scan_done;  // every entry read and processed
    } awcr_status_t;

endpackage

`default_nettype wire

### rtl/awcr_ctrl.sv
`default_nettype none

module awcr_ctrl
    import awcr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire awcr_status_t status,
    output awcr_cmd_t         cmd
);

    awcr_state_t state_reg;
    awcr_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (status.is_clear || status.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/awcr_datapath.sv
`default_nettype none

module awcr_datapath
    import awcr_pkg::*;
#(
    parameter int ENTRIES     = 8,
    parameter int KEY_BITS    = 32,
    parameter int WEIGHT_BITS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         opcode,
    input  wire logic [31:0]  lookup_key,
    input  wire awcr_cmd_t    cmd,
    output awcr_status_t      status,
    output logic              hit,
    output logic [2:0]        slot,
    output logic              evicted,
    output logic [31:0]       evicted_key
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_ONE = WEIGHT_BITS'(1);

    logic [KEY_BITS-1:0]           key_mem [ENTRIES];
    logic signed [WEIGHT_BITS-1:0] weight_mem [ENTRIES];
    logic [ENTRIES-1:0]            valid_reg;

    logic                          op_reg;
    logic [KEY_BITS-1:0]           key_reg;
    logic [CNT_W-1:0]              rd_cnt_reg;
    logic                          proc_vld_reg;
    logic [IDX_W-1:0]              proc_idx_reg;
    logic [KEY_BITS-1:0]           key_rd_reg;
    logic signed [WEIGHT_BITS-1:0] weight_rd_reg;

    logic                          match_found_reg;
    logic [IDX_W-1:0]              match_idx_reg;
    logic                          empty_found_reg;
    logic [IDX_W-1:0]              empty_idx_reg;
    logic                          min_found_reg;
    logic [IDX_W-1:0]              min_idx_reg;
    logic signed [WEIGHT_BITS-1:0] min_w_reg;
    logic [KEY_BITS-1:0]           min_key_reg;

    logic                          hit_reg;
    logic [2:0]                    slot_reg;
    logic                          evicted_reg;
    logic [31:0]                   evicted_key_reg;

    logic                          rd_issue;
    logic [IDX_W-1:0]              rd_addr;
    logic                          proc_en;
    logic                          ent_valid;
    logic                          ent_match;
    logic signed [WEIGHT_BITS-1:0] new_w;
    logic [IDX_W-1:0]              victim;
    logic                          do_fill;
    logic                          w_we;
    logic [IDX_W-1:0]              w_addr;
    logic signed [WEIGHT_BITS-1:0] w_data;
    logic [IDX_W+2:0]              slot_wide;

    assign rd_issue  = cmd.step && (rd_cnt_reg < CNT_W'(ENTRIES));
    assign rd_addr   = rd_cnt_reg[IDX_W-1:0];
    assign proc_en   = proc_vld_reg && (op_reg == OP_ACCESS);
    assign ent_valid = valid_reg[proc_idx_reg];
    assign ent_match = (key_rd_reg == key_reg);

    always_comb
    begin
        if (ent_match)
        begin
            new_w = (weight_rd_reg == W_MAX) ? W_MAX : weight_rd_reg + W_ONE;
        end
        else
        begin
            new_w = (weight_rd_reg == W_MIN) ? W_MIN : weight_rd_reg - W_ONE;
        end
    end

    // empty slot first, else the first lowest weight
    assign victim  = empty_found_reg ? empty_idx_reg : min_idx_reg;
    assign do_fill = cmd.commit && (op_reg == OP_ACCESS) && !match_found_reg;

    always_comb
    begin
        w_we   = 1'b0;
        w_addr = proc_idx_reg;
        w_data = new_w;
        if (do_fill)
        begin
            w_we   = 1'b1;
            w_addr = victim;
            w_data = W_ONE;
        end
        else if (proc_en && ent_valid)
        begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            weight_mem[w_addr] <= w_data;
        end
        if (do_fill)
        begin
            key_mem[victim] <= key_reg;
        end
        key_rd_reg    <= key_mem[rd_addr];
        weight_rd_reg <= weight_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            proc_vld_reg <= 1'b0;
            rd_cnt_reg   <= '0;
        end
        else
        begin
            proc_vld_reg <= rd_issue;
            if (cmd.start)
            begin
                rd_cnt_reg <= '0;
            end
            else if (rd_issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            end
            if (cmd.commit && (op_reg == OP_CLEAR))
            begin
                valid_reg <= '0;
            end
            else if (do_fill)
            begin
                valid_reg[victim] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg <= rd_addr;
        if (cmd.start)
        begin
            op_reg          <= opcode;
            key_reg         <= KEY_BITS'(lookup_key);
            match_found_reg <= 1'b0;
            empty_found_reg <= 1'b0;
            min_found_reg   <= 1'b0;
        end
        else if (proc_en)
        begin
            if (ent_valid)
            begin
                if (ent_match && !match_found_reg)
                begin
                    match_found_reg <= 1'b1;
                    match_idx_reg   <= proc_idx_reg;
                end
                if (!min_found_reg || (new_w < min_w_reg))
                begin
                    min_found_reg <= 1'b1;
                    min_idx_reg   <= proc_idx_reg;
                    min_w_reg     <= new_w;
                    min_key_reg   <= key_rd_reg;
                end
            end
            else if (!empty_found_reg)
            begin
                empty_found_reg <= 1'b1;
                empty_idx_reg   <= proc_idx_reg;
            end
        end
    end

    always_comb
    begin
        slot_wide = '0;
        if (op_reg == OP_ACCESS)
        begin
            slot_wide = (IDX_W + 3)'(match_found_reg ? match_idx_reg : victim);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg         <= (op_reg == OP_ACCESS) && match_found_reg;
            slot_reg        <= slot_wide[2:0];
            evicted_reg     <= do_fill && !empty_found_reg;
            evicted_key_reg <= (do_fill && !empty_found_reg) ? 32'(min_key_reg) : 32'd0;
        end
    end

    assign status.is_clear  = (op_reg == OP_CLEAR);
    assign status.scan_done = (rd_cnt_reg == CNT_W'(ENTRIES)) && !proc_vld_reg;

    assign hit         = hit_reg;
    assign slot        = slot_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

endmodule

`default_nettype wire

### rtl/aging_weight_cache_replacer.sv
// one request at a time: the next request is taken only after the previous result is loaded
//   into the output register; an access scans every entry, a clear marks every entry invalid
// the access scan reads one entry a cycle through the key and weight memories
// reset clears the state machine, the result valid flag and all entry valid bits;
//   key and weight memories are not cleared
`default_nettype none

module aging_weight_cache_replacer
    import awcr_pkg::*;
#(
    parameter int ENTRIES     = 8,
    parameter int KEY_BITS    = 32,
    parameter int WEIGHT_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        opcode,
    input  wire logic [31:0] lookup_key,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             hit,
    output logic [2:0]       slot,
    output logic             evicted,
    output logic [31:0]      evicted_key
);

    awcr_cmd_t    cmd;
    awcr_status_t status;

    awcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    awcr_datapath #(
        .ENTRIES     (ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .opcode      (opcode),
        .lookup_key  (lookup_key),
        .cmd         (cmd),
        .status      (status),
        .hit         (hit),
        .slot        (slot),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

endmodule

`default_nettype wire

### rtl/awcr_checker.sv
`default_nettype none

module awcr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        opcode,
    input wire logic [31:0] lookup_key,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        hit,
    input wire logic [2:0]  slot,
    input wire logic        evicted,
    input wire logic [31:0] evicted_key
);

    // one request at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in flight");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
        else $error("hit reported together with an eviction");

    a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted |-> evicted_key == 32'd0)
        else $error("evicted key set without an eviction");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(evicted_key))
        else $error("stalled result changed");

endmodule

bind aging_weight_cache_replacer awcr_checker u_awcr_checker (.*);

`default_nettype wire
